// ===== rtl/btu_pkg.sv =====
// Shared types and constants for the breakpoint table unit.
package btu_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] OPC_SET     = 3'd0;
   localparam logic [2:0] OPC_CLEAR   = 3'd1;
   localparam logic [2:0] OPC_CHECK   = 3'd2;
   localparam logic [2:0] OPC_PRESENT = 3'd3;
   localparam logic [2:0] OPC_READ    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [30:0] ID_MAX = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      OP_SET,
      OP_CLEAR,
      OP_CHECK,
      OP_PRESENT,
      OP_READ,
      OP_NONE
   } op_type;

   // Classified command passed from front to back
   typedef struct packed {
      op_type      op;
      logic [29:0] key_word;
      logic        key_ok;
      logic        clear_all;
      logic        temp;
      logic [31:0] skip;
      logic [30:0] tid;
      logic [5:0]  idx;
   } cmd_type;

   // One table entry
   typedef struct packed {
      logic [29:0] word;
      logic [30:0] id;
      logic [31:0] hits;
      logic [31:0] skip;
      logic        temp;
   } slot_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN_ADDR,
      BK_SCAN_TEST,
      BK_MOVE_RD,
      BK_MOVE_WR,
      BK_READ_DATA
   } bk_state_type;

endpackage

// ===== rtl/btu_front.sv =====
// Front end: accepts request beats, classifies them and queues commands.
module btu_front import btu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_address,
   input  logic        req_temporary_flag,
   input  logic [31:0] req_skip_hits,
   input  logic [30:0] req_target_id,
   input  logic [5:0]  req_entry_index,
   output logic        cmd_valid,
   output cmd_type     cmd_head,
   input  logic        cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   cmd_type    cmd_in;
   logic       push;

   // Decode opcode and precompute match keys
   always_comb begin
      cmd_in.key_word  = req_address[31:2];
      cmd_in.key_ok    = (req_address[1:0] == 2'b00);
      cmd_in.clear_all = (req_target_id == 31'd0);
      cmd_in.temp      = req_temporary_flag;
      cmd_in.skip      = req_skip_hits;
      cmd_in.tid       = req_target_id;
      cmd_in.idx       = req_entry_index;
      unique case (req_opcode)
         OPC_SET: begin
            cmd_in.op     = OP_SET;
            cmd_in.key_ok = 1'b1;
         end
         OPC_CLEAR:   cmd_in.op = OP_CLEAR;
         OPC_CHECK:   cmd_in.op = OP_CHECK;
         OPC_PRESENT: cmd_in.op = OP_PRESENT;
         OPC_READ:    cmd_in.op = OP_READ;
         default:     cmd_in.op = OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];

   // Two-deep command queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (cmd_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, cmd_pop};
      end
   end

endmodule

// ===== rtl/btu_back.sv =====
// Back end: table memory, scan sequencer and result register.
module btu_back import btu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd_head,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_stop,
   output logic        rsp_present,
   output logic [30:0] rsp_result_id,
   output logic [6:0]  rsp_removed_count,
   output logic [31:0] rsp_entry_address,
   output logic [31:0] rsp_entry_hit_count,
   output logic        rsp_entry_is_temporary,
   output logic [6:0]  rsp_entry_total
);

   slot_type     mem [TABLE_ENTRIES];
   slot_type     rd_ff;
   logic         mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   slot_type     mem_wdata;

   bk_state_type state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in, used_ff, used_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [30:0]  nid_ff, nid_in;
   logic         finish;
   logic         valid_ff;

   logic [1:0]  status_in;
   logic        stop_in, present_in, temp_out_in;
   logic [30:0] id_in;
   logic [6:0]  removed_in;
   logic [31:0] eaddr_in, ehits_in;
   logic        hit;

   logic [1:0]  status_ff;
   logic        stop_ff, present_ff, temp_out_ff;
   logic [30:0] id_ff;
   logic [6:0]  removed_ff, total_ff;
   logic [31:0] eaddr_ff, ehits_ff;

   // Table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[mem_raddr];
   end

   // Key compare on the entry just read
   always_comb begin
      if (cmd_ff.op == OP_CLEAR) hit = (rd_ff.id == cmd_ff.tid);
      else hit = cmd_ff.key_ok && (rd_ff.word == cmd_ff.key_word);
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      ptr_in      = ptr_ff;
      pos_in      = pos_ff;
      used_in     = used_ff;
      nid_in      = nid_ff;
      cmd_pop     = 1'b0;
      finish      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff;
      mem_wdata   = rd_ff;
      mem_raddr   = IDX_W'(ptr_ff);
      status_in   = ST_OK;
      stop_in     = stop_ff;
      present_in  = 1'b0;
      id_in       = 31'd0;
      removed_in  = 7'd0;
      eaddr_in    = 32'd0;
      ehits_in    = 32'd0;
      temp_out_in = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            stop_in = 1'b0;
            mem_raddr = IDX_W'(cmd_head.idx);
            if (cmd_valid && !valid_ff) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               ptr_in  = '0;
               unique case (cmd_head.op)
                  OP_READ: begin
                     if (32'(cmd_head.idx) >= 32'(used_ff)) begin
                        status_in = ST_RANGE;
                        finish    = 1'b1;
                     end else begin
                        state_in = BK_READ_DATA;
                     end
                  end
                  OP_CLEAR: begin
                     if (cmd_head.clear_all) begin
                        removed_in = 7'(used_ff);
                        used_in    = '0;
                        finish     = 1'b1;
                     end else begin
                        state_in = BK_SCAN_ADDR;
                     end
                  end
                  OP_NONE: finish = 1'b1;
                  default: state_in = BK_SCAN_ADDR;
               endcase
            end
         end
         BK_SCAN_ADDR: begin
            if (ptr_ff >= used_ff) begin
               // no entry matched
               if (cmd_ff.op == OP_SET) begin
                  if (used_ff >= CNT_W'(TABLE_ENTRIES)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we         = 1'b1;
                     mem_waddr      = IDX_W'(used_ff);
                     mem_wdata.word = cmd_ff.key_word;
                     mem_wdata.id   = nid_ff;
                     mem_wdata.hits = 32'd0;
                     mem_wdata.skip = cmd_ff.skip;
                     mem_wdata.temp = cmd_ff.temp;
                     id_in          = nid_ff;
                     used_in        = used_ff + 1'b1;
                     nid_in         = (nid_ff == ID_MAX) ? 31'd1 : nid_ff + 31'd1;
                  end
               end
               finish   = 1'b1;
               state_in = BK_IDLE;
            end else begin
               state_in = BK_SCAN_TEST;
            end
         end
         BK_SCAN_TEST: begin
            if (hit) begin
               pos_in    = IDX_W'(ptr_ff);
               mem_waddr = IDX_W'(ptr_ff);
               state_in  = BK_IDLE;
               case (cmd_ff.op)
                  OP_SET: begin
                     mem_we         = 1'b1;
                     mem_wdata.skip = cmd_ff.skip;
                     mem_wdata.temp = cmd_ff.temp;
                     id_in          = rd_ff.id;
                     finish         = 1'b1;
                  end
                  OP_PRESENT: begin
                     present_in = 1'b1;
                     finish     = 1'b1;
                  end
                  OP_CLEAR: state_in = BK_MOVE_RD;
                  default: begin
                     // check: count the hit
                     mem_wdata.hits = rd_ff.hits + 32'd1;
                     if (rd_ff.skip != 32'd0) begin
                        mem_we         = 1'b1;
                        mem_wdata.skip = rd_ff.skip - 32'd1;
                        finish         = 1'b1;
                     end else if (rd_ff.temp) begin
                        stop_in  = 1'b1;
                        state_in = BK_MOVE_RD;
                     end else begin
                        mem_we  = 1'b1;
                        stop_in = 1'b1;
                        finish  = 1'b1;
                     end
                  end
               endcase
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = BK_SCAN_ADDR;
            end
         end
         BK_MOVE_RD: begin
            mem_raddr = IDX_W'(used_ff - 1'b1);
            state_in  = BK_MOVE_WR;
         end
         BK_MOVE_WR: begin
            // last entry fills the gap
            mem_we     = 1'b1;
            used_in    = used_ff - 1'b1;
            removed_in = (cmd_ff.op == OP_CLEAR) ? 7'd1 : 7'd0;
            finish     = 1'b1;
            state_in   = BK_IDLE;
         end
         BK_READ_DATA: begin
            id_in       = rd_ff.id;
            eaddr_in    = {rd_ff.word, 2'b00};
            ehits_in    = rd_ff.hits;
            temp_out_in = rd_ff.temp;
            finish      = 1'b1;
            state_in    = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         used_ff  <= '0;
         nid_ff   <= 31'd1;
         valid_ff <= 1'b0;
         stop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         nid_ff   <= nid_in;
         stop_ff  <= finish ? 1'b0 : stop_in;
         if (finish) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      if (finish) begin
         status_ff   <= status_in;
         temp_out_ff <= temp_out_in;
         present_ff  <= present_in;
         id_ff       <= id_in;
         removed_ff  <= removed_in;
         eaddr_ff    <= eaddr_in;
         ehits_ff    <= ehits_in;
         total_ff    <= 7'(used_in);
      end
   end

   logic rstop_ff;
   always_ff @(posedge clock) begin
      if (finish) rstop_ff <= stop_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_stop               = rstop_ff;
   assign rsp_present            = present_ff;
   assign rsp_result_id          = id_ff;
   assign rsp_removed_count      = removed_ff;
   assign rsp_entry_address      = eaddr_ff;
   assign rsp_entry_hit_count    = ehits_ff;
   assign rsp_entry_is_temporary = temp_out_ff;
   assign rsp_entry_total        = total_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count above table size");
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !valid_ff && state_ff == BK_IDLE)
      else $error("command taken while result pending");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      finish |-> !valid_ff)
      else $error("result overwritten");
   a_move_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_MOVE_RD |-> used_ff != '0)
      else $error("remove from empty table");

endmodule

// ===== rtl/breakpoint_table_unit_core.sv =====
// Top level of the breakpoint table unit.
// Request beats (req_*) carry one operation: set, clear, check, present or
// read. Each request gives exactly one response beat (rsp_*) with status,
// per-operation fields and the entry count after the operation.
// A valid beat is taken at a clock edge where valid is high and stall low.
// Requests enter a two-deep command queue; req_stall rises when it is full.
// The back end scans the table memory one entry at a time, with a
// registered read and a compare per entry. Set, check, present and clear
// by id scan until a match or the last used entry; a removal then moves
// the last entry into the gap. Read does one registered table read;
// clear-all and unknown opcodes finish straight from idle.
// The response is registered and shows up on the cycle after the operation finishes.
// One operation is in the back end at a time. A response sits in the
// output register while rsp_stall is high; the next command starts on the
// cycle after it has been taken, while the queue keeps accepting requests.
// Reset (synchronous, active high) empties the table and queue and sets
// the id counter to 1; the table memory needs no clearing pass.
module breakpoint_table_unit_core import btu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_address,
   input  logic        req_temporary_flag,
   input  logic [31:0] req_skip_hits,
   input  logic [30:0] req_target_id,
   input  logic [5:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_stop,
   output logic        rsp_present,
   output logic [30:0] rsp_result_id,
   output logic [6:0]  rsp_removed_count,
   output logic [31:0] rsp_entry_address,
   output logic [31:0] rsp_entry_hit_count,
   output logic        rsp_entry_is_temporary,
   output logic [6:0]  rsp_entry_total
);

   logic    cmd_valid, cmd_pop;
   cmd_type cmd_head;

   btu_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_address,
      .req_temporary_flag, .req_skip_hits, .req_target_id, .req_entry_index,
      .cmd_valid, .cmd_head, .cmd_pop
   );

   btu_back u_back (
      .clock, .reset,
      .cmd_valid, .cmd_head, .cmd_pop,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_stop, .rsp_present,
      .rsp_result_id, .rsp_removed_count, .rsp_entry_address,
      .rsp_entry_hit_count, .rsp_entry_is_temporary, .rsp_entry_total
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the breakpoint table unit core.
`timescale 1ns / 1ps

module testbench;
   import btu_pkg::*;

   localparam int IDLE_PCT   = 22;
   localparam int WDOG_LIMIT = 20000;

   typedef struct {
      logic [1:0]  status;
      logic        stop;
      logic        present;
      logic [30:0] result_id;
      logic [6:0]  removed_count;
      logic [31:0] entry_address;
      logic [31:0] entry_hit_count;
      logic        entry_is_temporary;
      logic [6:0]  entry_total;
   } bp_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [31:0] req_address;
   logic        req_temporary_flag;
   logic [31:0] req_skip_hits;
   logic [30:0] req_target_id;
   logic [5:0]  req_entry_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic        rsp_stop;
   logic        rsp_present;
   logic [30:0] rsp_result_id;
   logic [6:0]  rsp_removed_count;
   logic [31:0] rsp_entry_address;
   logic [31:0] rsp_entry_hit_count;
   logic        rsp_entry_is_temporary;
   logic [6:0]  rsp_entry_total;

   // Shadow copy of the table
   logic [29:0] tbl_word [TABLE_ENTRIES];
   logic [30:0] tbl_id   [TABLE_ENTRIES];
   logic [31:0] tbl_hits [TABLE_ENTRIES];
   logic [31:0] tbl_skip [TABLE_ENTRIES];
   logic        tbl_temp [TABLE_ENTRIES];
   int          tbl_used;
   logic [30:0] tbl_next_id;

   bp_result_type expected_rsp_q[$];
   int          error_count;
   int          idle_cycles;
   bit          no_idle;
   bit          hold_rsp;
   bit          run_done;

   breakpoint_table_unit_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Table model helpers
   function automatic int find_addr(logic [31:0] addr);
      if (addr[1:0] != 2'b00) return -1;
      for (int i = 0; i < tbl_used; i++)
         if (tbl_word[i] == addr[31:2]) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int p);
      int last;
      last = tbl_used - 1;
      tbl_word[p] = tbl_word[last];
      tbl_id[p]   = tbl_id[last];
      tbl_hits[p] = tbl_hits[last];
      tbl_skip[p] = tbl_skip[last];
      tbl_temp[p] = tbl_temp[last];
      tbl_used    = last;
   endfunction

   // Apply one operation to the shadow table and return the response
   function automatic bp_result_type apply_op(logic [2:0] opc, logic [31:0] addr, logic temp,
                                              logic [31:0] skip, logic [30:0] tid,
                                              logic [5:0] idx);
      bp_result_type r;
      int p;
      r = '{default: '0};
      case (opc)
         OPC_SET: begin
            p = find_addr({addr[31:2], 2'b00});
            if (p >= 0) begin
               tbl_temp[p] = temp;
               tbl_skip[p] = skip;
               r.result_id = tbl_id[p];
            end else if (tbl_used >= TABLE_ENTRIES) begin
               r.status = ST_FULL;
            end else begin
               tbl_word[tbl_used] = addr[31:2];
               tbl_id[tbl_used]   = tbl_next_id;
               tbl_hits[tbl_used] = '0;
               tbl_skip[tbl_used] = skip;
               tbl_temp[tbl_used] = temp;
               tbl_used++;
               r.result_id = tbl_next_id;
               tbl_next_id = (tbl_next_id == ID_MAX) ? 31'd1 : tbl_next_id + 31'd1;
            end
         end
         OPC_CLEAR: begin
            if (tid == '0) begin
               r.removed_count = 7'(tbl_used);
               tbl_used = 0;
            end else begin
               for (int i = 0; i < tbl_used; i++)
                  if (tbl_id[i] == tid) begin
                     drop_slot(i);
                     r.removed_count = 7'd1;
                     break;
                  end
            end
         end
         OPC_CHECK: begin
            p = find_addr(addr);
            if (p >= 0) begin
               tbl_hits[p]++;
               if (tbl_skip[p] != '0) tbl_skip[p]--;
               else begin
                  r.stop = 1'b1;
                  if (tbl_temp[p]) drop_slot(p);
               end
            end
         end
         OPC_PRESENT: r.present = (find_addr(addr) >= 0);
         OPC_READ: begin
            if (idx >= tbl_used) r.status = ST_RANGE;
            else begin
               r.result_id          = tbl_id[idx];
               r.entry_address      = {tbl_word[idx], 2'b00};
               r.entry_hit_count    = tbl_hits[idx];
               r.entry_is_temporary = tbl_temp[idx];
            end
         end
         default: ;
      endcase
      r.entry_total = 7'(tbl_used);
      return r;
   endfunction

   // Send one beat, then record its expected response once accepted
   task automatic send_op(logic [2:0] opc, logic [31:0] addr = '0, logic temp = 1'b0,
                          logic [31:0] skip = '0, logic [30:0] tid = '0,
                          logic [5:0] idx = '0);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= opc;
      req_address        <= addr;
      req_temporary_flag <= temp;
      req_skip_hits      <= skip;
      req_target_id      <= tid;
      req_entry_index    <= idx;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(apply_op(opc, addr, temp, skip, tid, idx));
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // Stop offering beats and wait for every response
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Response checker and receiver stall
   always @(posedge clock) begin
      bp_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch("status", 32'(rsp_status), 32'(e.status));
               if (rsp_stop !== e.stop)
                  report_mismatch("stop", 32'(rsp_stop), 32'(e.stop));
               if (rsp_present !== e.present)
                  report_mismatch("present", 32'(rsp_present), 32'(e.present));
               if (rsp_result_id !== e.result_id)
                  report_mismatch("result_id", 32'(rsp_result_id), 32'(e.result_id));
               if (rsp_removed_count !== e.removed_count)
                  report_mismatch("removed_count", 32'(rsp_removed_count),
                                  32'(e.removed_count));
               if (rsp_entry_address !== e.entry_address)
                  report_mismatch("entry_address", rsp_entry_address, e.entry_address);
               if (rsp_entry_hit_count !== e.entry_hit_count)
                  report_mismatch("entry_hit_count", rsp_entry_hit_count,
                                  e.entry_hit_count);
               if (rsp_entry_is_temporary !== e.entry_is_temporary)
                  report_mismatch("entry_is_temporary", 32'(rsp_entry_is_temporary),
                                  32'(e.entry_is_temporary));
               if (rsp_entry_total !== e.entry_total)
                  report_mismatch("entry_total", 32'(rsp_entry_total),
                                  32'(e.entry_total));
            end
         end
      end
      rsp_stall <= hold_rsp || (!no_idle && $urandom_range(99) < IDLE_PCT);
   end

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!run_done && idle_cycles >= WDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Random address near existing entries so hits are common
   function automatic logic [31:0] pick_addr();
      int k;
      k = $urandom_range(9);
      if (tbl_used > 0 && k < 6) return {tbl_word[$urandom_range(tbl_used - 1)], 2'b00};
      if (k < 8) return {30'($urandom_range(15)), $urandom_range(3) == 0 ? 2'($urandom) : 2'b00};
      return $urandom;
   endfunction

   task automatic test_directed();
      send_op(OPC_READ, '0, 1'b0, '0, '0, 6'd0);
      send_op(OPC_CLEAR, '0, 1'b0, '0, 31'd0);
      send_op(OPC_CLEAR, '0, 1'b0, '0, ID_MAX);
      send_op(OPC_CHECK, 32'h10);
      send_op(OPC_SET, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_op(OPC_SET, 32'h0000_0013, 1'b0, 32'd2);
      send_op(OPC_SET, 32'h0000_0010, 1'b1, 32'd0);   // update existing entry
      send_op(OPC_PRESENT, 32'h0000_0010);
      send_op(OPC_PRESENT, 32'h0000_0011);            // unaligned never matches
      send_op(OPC_CHECK, 32'h0000_0012);
      send_op(OPC_READ, '0, 1'b0, '0, '0, 6'd1);
      send_op(OPC_CHECK, 32'h0000_0010);              // temporary stop removes it
      send_op(OPC_READ, '0, 1'b0, '0, '0, 6'd63);
      send_op(OPC_SET, 32'h8000_0000, 1'b0, 32'd1);
      send_op(OPC_CHECK, 32'h8000_0000);              // skip running
      send_op(OPC_CHECK, 32'h8000_0000);
      send_op(OPC_READ, '0, 1'b0, '0, '0, 6'd1);
      send_op(3'd5, 32'hFFFF_FFFF, 1'b1, '1, ID_MAX, 6'd63);
      send_op(3'd6);
      send_op(3'd7);
      send_op(OPC_CLEAR, '0, 1'b0, '0, 31'd1);
      send_op(OPC_CLEAR, '0, 1'b0, '0, 31'd3);
      send_op(OPC_READ, '0, 1'b0, '0, '0, 6'd0);
      wait_drained();
   endtask

   // Fill to capacity, overflow, then clear all
   task automatic test_full_table();
      no_idle = 1'b1;
      for (int i = 0; i < TABLE_ENTRIES + 2; i++)
         send_op(OPC_SET, 32'h1000 + 4 * i, 1'(i), 32'(i));
      send_op(OPC_READ, '0, 1'b0, '0, '0, 6'd63);
      send_op(OPC_CHECK, 32'h1000 + 4 * 63);
      send_op(OPC_CLEAR, '0, 1'b0, '0, '0);
      no_idle = 1'b0;
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering beats
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_op(OPC_SET, 32'h40 * i, 1'b0, 32'd1);
      join
      wait_drained();
   endtask

   task automatic test_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) no_idle = 1'b1;
         if (i == n / 2) no_idle = 1'b0;
         k = $urandom_range(99);
         if (k < 30)
            send_op(OPC_SET, pick_addr(), 1'($urandom),
                    $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(2)));
         else if (k < 60) send_op(OPC_CHECK, pick_addr());
         else if (k < 70) send_op(OPC_PRESENT, pick_addr());
         else if (k < 82) send_op(OPC_READ, '0, 1'b0, '0, '0, 6'($urandom));
         else if (k < 94)
            send_op(OPC_CLEAR, '0, 1'b0, '0,
                    $urandom_range(19) == 0 ? 31'd0 :
                    ($urandom_range(4) == 0 ? 31'($urandom) : 31'($urandom_range(tbl_next_id))));
         else send_op(3'($urandom_range(7, 5)), $urandom, 1'($urandom), $urandom,
                      31'($urandom), 6'($urandom));
      end
      wait_drained();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_opcode         = '0;
      req_address        = '0;
      req_temporary_flag = 1'b0;
      req_skip_hits      = '0;
      req_target_id      = '0;
      req_entry_index    = '0;
      tbl_used           = 0;
      tbl_next_id        = 31'd1;
      error_count        = 0;
      no_idle            = 1'b0;
      hold_rsp           = 1'b0;
      run_done           = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random(450);
      repeat (300) @(posedge clock);
      run_done = 1'b1;
      if (error_count == 0 && expected_rsp_q.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
